[hw/rtl/tree_release_cover_select_top_assert.svh]
// assertion macros used by the cover-select sequencer rtl
`ifndef TREE_RELEASE_COVER_SELECT_TOP_ASSERT_SVH
`define TREE_RELEASE_COVER_SELECT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define TRCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled during reset
`define TRCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TRCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TRCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[hw/rtl/trcs_pkg.sv]
// shared types and constants for the tree cover-select block
`timescale 1ns / 1ps
`default_nettype none

package trcs_pkg;

    // fixed field widths
    localparam int MASK_W      = 64;
    localparam int NODE_W      = 7;
    localparam int ORD_W       = 5;
    localparam int DEPTH_W     = 3;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 3'd6;

    // commands from the sequencer to the level unit
    typedef struct packed {
        logic load_in;
        logic reload;
        logic fold;
        logic make_par;
        logic shift_cur;
        logic shift_par;
    } t_lvl_cmd;

    // bits the level unit shows to the sequencer
    typedef struct packed {
        logic cur_bit;
        logic par_bit;
    } t_lvl_stat;

endpackage

`default_nettype wire

[hw/rtl/trcs_ifs.sv]
// valid/ready channel interfaces for mask words and result words
`timescale 1ns / 1ps
`default_nettype none

interface trcs_in_if;
    logic                       valid;
    logic                       ready;
    logic [trcs_pkg::MASK_W-1:0] leaf_hidden_mask;

    modport source (output valid, output leaf_hidden_mask, input ready);
    modport sink   (input valid, input leaf_hidden_mask, output ready);
endinterface

interface trcs_out_if;
    logic                       valid;
    logic                       ready;
    logic [trcs_pkg::NODE_W-1:0] node_index;
    logic [trcs_pkg::ORD_W-1:0]  release_ordinal;
    logic                       none_released;
    logic                       last_of_run;

    modport source (output valid, output node_index, output release_ordinal,
                    output none_released, output last_of_run, input ready);
    modport sink   (input valid, input node_index, input release_ordinal,
                    input none_released, input last_of_run, output ready);
endinterface

`default_nettype wire

[hw/rtl/trcs_level_unit.sv]
// shared pair-fold unit holding the mask, the current level and its parent level
`timescale 1ns / 1ps
`default_nettype none

module trcs_level_unit #(
    parameter int MAX_DEPTH = 6
) (
    input  logic                          i_clk,
    input  logic [trcs_pkg::MASK_W-1:0]   i_mask,
    input  logic [trcs_pkg::DEPTH_W-1:0]  i_depth,
    input  trcs_pkg::t_lvl_cmd            i_cmd,
    output trcs_pkg::t_lvl_stat           o_stat
);
    import trcs_pkg::*;

    localparam int LEAVES = 1 << MAX_DEPTH;
    localparam int CNT_W  = MAX_DEPTH + 1;

    // or adjacent pairs: one tree level up, upper half cleared
    function automatic logic [LEAVES-1:0] fold_pairs(input logic [LEAVES-1:0] v);
        logic [LEAVES-1:0] f;
        f = '0;
        for (int p = 0; p < LEAVES / 2; p++) begin
            f[p] = v[2*p] | v[2*p+1];
        end
        return f;
    endfunction

    logic [LEAVES-1:0] r_mask;
    logic [LEAVES-1:0] r_cur;
    logic [LEAVES-1:0] r_par;
    logic [CNT_W-1:0]  leaf_cnt;
    logic [LEAVES-1:0] leaf_keep;
    logic [LEAVES-1:0] masked_in;

    // drop flags above the leaf count
    assign leaf_cnt  = CNT_W'(1) << i_depth;
    assign leaf_keep = ~({LEAVES{1'b1}} << leaf_cnt);
    assign masked_in = i_mask[LEAVES-1:0] & leaf_keep;

    // mask capture and level registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mask <= masked_in;
            r_cur  <= masked_in;
        end else if (i_cmd.reload) begin
            r_cur  <= r_mask;
        end else if (i_cmd.fold) begin
            r_cur  <= fold_pairs(r_cur);
        end else if (i_cmd.shift_cur) begin
            r_cur  <= r_cur >> 1;
        end

        if (i_cmd.make_par) begin
            r_par <= fold_pairs(r_cur);
        end else if (i_cmd.shift_par) begin
            r_par <= r_par >> 1;
        end
    end

    assign o_stat.cur_bit = r_cur[0];
    assign o_stat.par_bit = r_par[0];

endmodule

`default_nettype wire

[hw/rtl/trcs_ctrl.sv]
// sequencer: config register, level/position walk, hold slot and output word register
`timescale 1ns / 1ps
`default_nettype none

`include "tree_release_cover_select_top_assert.svh"

module trcs_ctrl #(
    parameter int MAX_DEPTH = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [trcs_pkg::DEPTH_W-1:0]  i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [trcs_pkg::NODE_W-1:0]   o_node_index,
    output logic [trcs_pkg::ORD_W-1:0]    o_release_ordinal,
    output logic                          o_none_released,
    output logic                          o_last_of_run,
    output logic [trcs_pkg::DEPTH_W-1:0]  o_depth,
    output trcs_pkg::t_lvl_cmd            o_cmd,
    input  trcs_pkg::t_lvl_stat           i_stat
);
    import trcs_pkg::*;

    localparam int POS_W = MAX_DEPTH;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FOLD  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [DEPTH_W-1:0]  r_tree_depth;
    logic [DEPTH_W-1:0]  r_level, n_level;
    logic [DEPTH_W-1:0]  r_fold_cnt, n_fold_cnt;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [ORD_W-1:0]    r_count, n_count;
    logic                r_hold_vld, n_hold_vld;
    logic [NODE_W-1:0]   r_hold_idx, n_hold_idx;
    logic [ORD_W-1:0]    r_hold_ord, n_hold_ord;
    logic                r_out_vld;
    logic [NODE_W-1:0]   r_out_idx, n_out_idx;
    logic [ORD_W-1:0]    r_out_ord, n_out_ord;
    logic                r_out_none, n_out_none;
    logic                r_out_last, n_out_last;

    logic [DEPTH_W-1:0]  eff_depth;
    logic [POS_W:0]      level_span;
    logic [POS_W-1:0]    last_pos;
    logic [NODE_W-1:0]   node_idx;
    logic                qualify;
    logic                out_free;
    logic                out_load;
    logic                stall;
    t_lvl_cmd            cmd;

    // clamp the configured depth into 1..MAX_DEPTH
    always_comb begin
        if (r_tree_depth == '0) begin
            eff_depth = DEPTH_W'(1);
        end else if (r_tree_depth > DEPTH_W'(MAX_DEPTH)) begin
            eff_depth = DEPTH_W'(MAX_DEPTH);
        end else begin
            eff_depth = r_tree_depth;
        end
    end

    // position decode within the current level
    assign level_span = (POS_W + 1)'(1) << r_level;
    assign last_pos   = POS_W'(level_span - (POS_W + 1)'(1));
    assign node_idx   = NODE_W'(level_span - (POS_W + 1)'(1)) + NODE_W'(r_pos);
    assign qualify    = !i_stat.cur_bit && i_stat.par_bit;
    assign out_free   = !r_out_vld || i_out_ready;
    assign stall      = qualify && r_hold_vld && !out_free;

    // next-state logic
    always_comb begin
        n_state    = r_state;
        n_level    = r_level;
        n_fold_cnt = r_fold_cnt;
        n_pos      = r_pos;
        n_count    = r_count;
        n_hold_vld = r_hold_vld;
        n_hold_idx = r_hold_idx;
        n_hold_ord = r_hold_ord;
        n_out_idx  = r_out_idx;
        n_out_ord  = r_out_ord;
        n_out_none = r_out_none;
        n_out_last = r_out_last;
        out_load   = 1'b0;
        cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_level     = DEPTH_W'(1);
                    n_fold_cnt  = eff_depth - DEPTH_W'(1);
                    n_count     = '0;
                    n_hold_vld  = 1'b0;
                    n_state     = S_FOLD;
                end
            end
            S_FOLD: begin
                if (r_fold_cnt != '0) begin
                    cmd.fold   = 1'b1;
                    n_fold_cnt = r_fold_cnt - DEPTH_W'(1);
                end else begin
                    cmd.make_par = 1'b1;
                    n_pos        = '0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!stall) begin
                    // a new find pushes the held word out as not-last
                    if (qualify) begin
                        if (r_hold_vld) begin
                            out_load   = 1'b1;
                            n_out_idx  = r_hold_idx;
                            n_out_ord  = r_hold_ord;
                            n_out_none = 1'b0;
                            n_out_last = 1'b0;
                        end
                        n_hold_vld = 1'b1;
                        n_hold_idx = node_idx;
                        n_hold_ord = r_count;
                        n_count    = r_count + ORD_W'(1);
                    end
                    cmd.shift_cur = 1'b1;
                    cmd.shift_par = r_pos[0];
                    if (r_pos == last_pos) begin
                        if (r_level == eff_depth) begin
                            n_state = S_FLUSH;
                        end else begin
                            cmd.reload = 1'b1;
                            n_level    = r_level + DEPTH_W'(1);
                            n_fold_cnt = eff_depth - r_level - DEPTH_W'(1);
                            n_state    = S_FOLD;
                        end
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out_last = 1'b1;
                    n_out_none = !r_hold_vld;
                    n_out_idx  = r_hold_vld ? r_hold_idx : '0;
                    n_out_ord  = r_hold_vld ? r_hold_ord : '0;
                    n_hold_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tree_depth <= DEPTH_RESET;
            r_hold_vld   <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_hold_vld <= n_hold_vld;
            if (i_cfg_wr_en) begin
                r_tree_depth <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // walk counters and payload registers
    always_ff @(posedge i_clk) begin
        r_level    <= n_level;
        r_fold_cnt <= n_fold_cnt;
        r_pos      <= n_pos;
        r_count    <= n_count;
        r_hold_idx <= n_hold_idx;
        r_hold_ord <= n_hold_ord;
        r_out_idx  <= n_out_idx;
        r_out_ord  <= n_out_ord;
        r_out_none <= n_out_none;
        r_out_last <= n_out_last;
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_vld;
    assign o_node_index      = r_out_idx;
    assign o_release_ordinal = r_out_ord;
    assign o_none_released   = r_out_none;
    assign o_last_of_run     = r_out_last;
    assign o_depth           = eff_depth;
    assign o_cmd             = cmd;

    // checks
    `TRCS_ASSERT_IMP(a_none_word_clean, i_clk, i_rst_n, r_out_vld && r_out_none, r_out_last && (r_out_idx == '0) && (r_out_ord == '0), "empty word carries data")
    `TRCS_ASSERT_IMP(a_level_range, i_clk, i_rst_n, (r_state == S_SCAN) || (r_state == S_FOLD), (r_level != '0) && (r_level <= eff_depth), "level outside tree")
    `TRCS_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, r_state == S_SCAN, (POS_W + 1)'(r_pos) < level_span, "position past end of level")
    `TRCS_ASSERT_NXT(a_flush_ends_run, i_clk, i_rst_n, (r_state == S_FLUSH) && out_free, r_out_vld && r_out_last && (r_state == S_IDLE) && !r_hold_vld, "flush did not close the run")

endmodule

`default_nettype wire

[hw/rtl/tree_release_cover_select_top.sv]
// walk: one fold unit rebuilds each level from the leaves, then a scan visits one node per
// cycle unless a new find meets a full hold slot and a full output register; the final result
// word also waits while the result side holds ready low
// a new mask word is taken only in idle, after the previous run's last word is loaded;
// results leave at most one per cycle
// reset: synchronous active-low i_rst_n; depth register returns to 6, walk and output idle
`timescale 1ns / 1ps
`default_nettype none

module tree_release_cover_select_top #(
    parameter int MAX_DEPTH = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [trcs_pkg::DEPTH_W-1:0]  i_cfg_wr_data,
    trcs_in_if.sink                       i_in,
    trcs_out_if.source                    o_out
);
    import trcs_pkg::*;

    t_lvl_cmd            lvl_cmd;
    t_lvl_stat           lvl_stat;
    logic [DEPTH_W-1:0]  eff_depth;

    // level builder
    trcs_level_unit #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_level (
        .i_clk   (i_clk),
        .i_mask  (i_in.leaf_hidden_mask),
        .i_depth (eff_depth),
        .i_cmd   (lvl_cmd),
        .o_stat  (lvl_stat)
    );

    // sequencer and output word register
    trcs_ctrl #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in.valid),
        .o_in_ready        (i_in.ready),
        .o_out_valid       (o_out.valid),
        .i_out_ready       (o_out.ready),
        .o_node_index      (o_out.node_index),
        .o_release_ordinal (o_out.release_ordinal),
        .o_none_released   (o_out.none_released),
        .o_last_of_run     (o_out.last_of_run),
        .o_depth           (eff_depth),
        .o_cmd             (lvl_cmd),
        .i_stat            (lvl_stat)
    );

endmodule

`default_nettype wire
